>>> rtl/udp_over_tcp_deframer_assert.svh
// Assertion macros used by the deframer parser RTL.
`ifndef UDP_OVER_TCP_DEFRAMER_ASSERT_SVH
`define UDP_OVER_TCP_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset.
`define UTDF_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
// Next-cycle implication, disabled in reset.
`define UTDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define UTDF_ASSERT(lbl, clk, rst_n, ante, cons)
`define UTDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/utdf_pkg.sv
package utdf_pkg;

    typedef enum logic [2:0] {
        ROLE_TYPE    = 3'd0,
        ROLE_ADDRESS = 3'd1,
        ROLE_DOMLEN  = 3'd2,
        ROLE_PORT    = 3'd3,
        ROLE_LENGTH  = 3'd4,
        ROLE_PAYLOAD = 3'd5,
        ROLE_NONE    = 3'd6
    } role_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DECODE   = 2'd1,
        ST_BADADDR  = 2'd2,
        ST_CLEANEND = 2'd3
    } status_t;

    localparam logic [7:0] TYPE_IPV4     = 8'h00;
    localparam logic [7:0] TYPE_IPV6     = 8'h01;
    localparam logic [7:0] TYPE_DOMAIN   = 8'h02;
    localparam logic [7:0] IPV4_ADDR_LEN = 8'd4;
    localparam logic [7:0] IPV6_ADDR_LEN = 8'd16;

    typedef struct packed {
        logic [7:0] out_byte;
        role_t      role;
        logic       frame_last;
        logic       empty_frame;
        status_t    status;
    } result_t;

endpackage

>>> rtl/utdf_ifs.sv
interface utdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface utdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] byte_role;
    logic       frame_last;
    logic       empty_frame;
    logic [1:0] status;

    modport source (output valid, output out_byte, output byte_role, output frame_last,
                    output empty_frame, output status, input ready);
    modport sink (input valid, input out_byte, input byte_role, input frame_last,
                  input empty_frame, input status, output ready);
endinterface

interface utdf_cfg_if;
    logic valid;
    logic ready;
    logic connect_mode;

    modport source (output valid, output connect_mode, input ready);
    modport sink (input valid, input connect_mode, output ready);
endinterface

>>> rtl/utdf_parser.sv
`include "udp_over_tcp_deframer_assert.svh"

module utdf_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              end_of_stream,
    input  logic              connect_mode,
    output utdf_pkg::result_t res
);
    import utdf_pkg::*;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_ADDR    = 8'b0000_0010,
        PH_DOMLEN  = 8'b0000_0100,
        PH_PORT_HI = 8'b0000_1000,
        PH_PORT_LO = 8'b0001_0000,
        PH_LEN_HI  = 8'b0010_0000,
        PH_LEN_LO  = 8'b0100_0000,
        PH_PAYLOAD = 8'b1000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  field_rem_reg, field_rem_next;
    logic [7:0]  hold_reg, hold_next;
    logic [15:0] payload_rem_reg, payload_rem_next;
    status_t     sticky_reg, sticky_next;
    logic        pending_reg, pending_next;

    phase_t      ph;
    logic [7:0]  b;
    logic [7:0]  field_dec;
    logic [15:0] payload_dec;
    logic [15:0] frame_len;

    always_comb
    begin
        b           = end_of_stream ? 8'd0 : in_byte;
        field_dec   = field_rem_reg - 8'd1;
        payload_dec = payload_rem_reg - 16'd1;
        frame_len   = {hold_reg, b};
        ph          = (phase_reg == PH_START && connect_mode) ? PH_LEN_HI : phase_reg;

        phase_next       = phase_reg;
        field_rem_next   = field_rem_reg;
        hold_next        = hold_reg;
        payload_rem_next = payload_rem_reg;
        sticky_next      = sticky_reg;
        pending_next     = pending_reg;

        res.out_byte    = b;
        res.role        = ROLE_NONE;
        res.frame_last  = 1'b0;
        res.empty_frame = 1'b0;
        res.status      = ST_OK;

        if (sticky_reg != ST_OK)
        begin
            res.status = sticky_reg;
        end
        else if (end_of_stream)
        begin
            // clean only at a frame boundary in connect mode
            if (phase_reg == PH_START && !pending_reg && connect_mode)
                sticky_next = ST_CLEANEND;
            else
                sticky_next = ST_DECODE;
            pending_next = 1'b0;
            res.status   = sticky_next;
        end
        else if (pending_reg)
        begin
            // unknown type byte reports on the beat after it
            pending_next = 1'b0;
            sticky_next  = ST_BADADDR;
            res.status   = ST_BADADDR;
        end
        else
        begin
            unique case (ph)
                PH_START:
                begin
                    res.role = ROLE_TYPE;
                    case (b)
                        TYPE_IPV4:
                        begin
                            field_rem_next = IPV4_ADDR_LEN;
                            phase_next     = PH_ADDR;
                        end
                        TYPE_IPV6:
                        begin
                            field_rem_next = IPV6_ADDR_LEN;
                            phase_next     = PH_ADDR;
                        end
                        TYPE_DOMAIN:
                        begin
                            phase_next = PH_DOMLEN;
                        end
                        default:
                        begin
                            pending_next = 1'b1;
                        end
                    endcase
                end
                PH_DOMLEN:
                begin
                    res.role = ROLE_DOMLEN;
                    if (b == 8'd0)
                    begin
                        sticky_next = ST_DECODE;
                        res.status  = ST_DECODE;
                    end
                    else
                    begin
                        field_rem_next = b;
                        phase_next     = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    res.role       = ROLE_ADDRESS;
                    field_rem_next = field_dec;
                    if (field_dec == 8'd0)
                        phase_next = PH_PORT_HI;
                end
                PH_PORT_HI:
                begin
                    res.role   = ROLE_PORT;
                    hold_next  = b;
                    phase_next = PH_PORT_LO;
                end
                PH_PORT_LO:
                begin
                    res.role = ROLE_PORT;
                    if (hold_reg == 8'd0 && b == 8'd0)
                    begin
                        sticky_next = ST_BADADDR;
                        res.status  = ST_BADADDR;
                    end
                    else
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    res.role   = ROLE_LENGTH;
                    hold_next  = b;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    res.role         = ROLE_LENGTH;
                    payload_rem_next = frame_len;
                    if (frame_len == 16'd0)
                    begin
                        res.frame_last  = 1'b1;
                        res.empty_frame = 1'b1;
                        phase_next      = PH_START;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    res.role         = ROLE_PAYLOAD;
                    payload_rem_next = payload_dec;
                    if (payload_dec == 16'd0)
                    begin
                        res.frame_last = 1'b1;
                        phase_next     = PH_START;
                    end
                end
                default:
                begin
                    phase_next = PH_START;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            field_rem_reg   <= 8'd0;
            hold_reg        <= 8'd0;
            payload_rem_reg <= 16'd0;
            sticky_reg      <= ST_OK;
            pending_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            field_rem_reg   <= field_rem_next;
            hold_reg        <= hold_next;
            payload_rem_reg <= payload_rem_next;
            sticky_reg      <= sticky_next;
            pending_reg     <= pending_next;
        end
    end

    `UTDF_ASSERT_NEXT(a_sticky_holds, clk, rst_n, sticky_reg != ST_OK, sticky_reg == $past(sticky_reg))
    `UTDF_ASSERT(a_pending_at_start, clk, rst_n, pending_reg, sticky_reg == ST_OK && phase_reg == PH_START)
    `UTDF_ASSERT(a_payload_nonzero, clk, rst_n, phase_reg == PH_PAYLOAD, payload_rem_reg != 16'd0)
    `UTDF_ASSERT(a_addr_nonzero, clk, rst_n, phase_reg == PH_ADDR, field_rem_reg != 8'd0)
    `UTDF_ASSERT(a_last_role, clk, rst_n, accept && res.frame_last, res.role == ROLE_LENGTH || res.role == ROLE_PAYLOAD)

endmodule

>>> rtl/udp_over_tcp_deframer.sv
// Length-prefixed datagram deframer for a TCP byte stream.
// data:   one stream byte per beat (in_byte), or an end-of-stream beat.
// result: one beat per input beat: the byte, its role in the frame, frame_last,
//         empty_frame and status (ok, decode failure, invalid address, clean end).
// cfg:    write-only connect_mode; ready is always high. Write it only while the
//         block is idle. The mode is sampled at each frame start.
// A result is registered and appears in the cycle after its data beat is taken.
// Throughput: one beat per cycle; the parser updates in the accepting cycle and
// the output register frees the input side whenever result.ready is high or the
// output register is empty.
// Stall: while result.ready is low with a beat held, data.ready drops and the
// held beat stays stable.
// Reset (rst_n, async active low): connect_mode = 0, parser at frame start, no
// error, output register empty. An error or a clean end sticks until reset; later
// beats pass the byte with role none and the held status.
module udp_over_tcp_deframer (
    input  logic    clk,
    input  logic    rst_n,
    utdf_in_if.sink data,
    utdf_out_if.source result,
    utdf_cfg_if.sink cfg
);
    import utdf_pkg::*;

    logic    connect_mode_reg;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res;
    logic    accept;

    assign cfg.ready  = 1'b1;
    assign data.ready = !out_valid_reg || result.ready;
    assign accept     = data.valid && data.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            connect_mode_reg <= 1'b0;
        else if (cfg.valid)
            connect_mode_reg <= cfg.connect_mode;
    end

    utdf_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (data.in_byte),
        .end_of_stream (data.end_of_stream),
        .connect_mode  (connect_mode_reg),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = res_reg.out_byte;
    assign result.byte_role   = res_reg.role;
    assign result.frame_last  = res_reg.frame_last;
    assign result.empty_frame = res_reg.empty_frame;
    assign result.status      = res_reg.status;

endmodule

>>> dv/tb_udp_over_tcp_deframer.sv
`timescale 1ns / 100ps

module tb_udp_over_tcp_deframer;

    import utdf_pkg::*;

    typedef enum logic [2:0] {
        P_START,
        P_ADDR,
        P_DOMLEN,
        P_PORT_HI,
        P_PORT_LO,
        P_LEN_HI,
        P_LEN_LO,
        P_PAYLOAD
    } parse_phase_t;

    class deframe_scoreboard;
        bit           connect_mode;
        parse_phase_t phase;
        logic [7:0]   addr_left;
        logic [7:0]   hold_byte;
        logic [15:0]  payload_left;
        status_t      held_status;
        bit           type_pending;
        result_t      tags_due[$];
        int unsigned  tag_mismatches;

        function new();
            connect_mode = 1'b0;
            phase = P_START;
            addr_left = 8'h00;
            hold_byte = 8'h00;
            payload_left = 16'h0000;
            held_status = ST_OK;
            type_pending = 1'b0;
            tag_mismatches = 0;
        endfunction

        function void set_mode(bit m);
            connect_mode = m;
        endfunction

        // Tag one accepted stream beat and queue the result it must produce.
        function void note_beat(logic [7:0] b, logic eos);
            result_t      t;
            parse_phase_t step;
            t.out_byte = eos ? 8'h00 : b;
            t.role = ROLE_NONE;
            t.frame_last = 1'b0;
            t.empty_frame = 1'b0;
            t.status = ST_OK;
            if (held_status != ST_OK)
                t.status = held_status;
            else if (eos)
            begin
                held_status = (phase == P_START && !type_pending && connect_mode) ?
                              ST_CLEANEND : ST_DECODE;
                type_pending = 1'b0;
                t.status = held_status;
            end
            else if (type_pending)
            begin
                // unknown type byte is flagged one beat late
                type_pending = 1'b0;
                held_status = ST_BADADDR;
                t.status = ST_BADADDR;
            end
            else
            begin
                step = (phase == P_START && connect_mode) ? P_LEN_HI : phase;
                case (step)
                    P_START:
                    begin
                        t.role = ROLE_TYPE;
                        if (b == TYPE_IPV4)
                        begin
                            addr_left = IPV4_ADDR_LEN;
                            phase = P_ADDR;
                        end
                        else if (b == TYPE_IPV6)
                        begin
                            addr_left = IPV6_ADDR_LEN;
                            phase = P_ADDR;
                        end
                        else if (b == TYPE_DOMAIN)
                            phase = P_DOMLEN;
                        else
                            type_pending = 1'b1;
                    end
                    P_DOMLEN:
                    begin
                        t.role = ROLE_DOMLEN;
                        if (b == 8'h00)
                        begin
                            held_status = ST_DECODE;
                            t.status = ST_DECODE;
                        end
                        else
                        begin
                            addr_left = b;
                            phase = P_ADDR;
                        end
                    end
                    P_ADDR:
                    begin
                        t.role = ROLE_ADDRESS;
                        addr_left = addr_left - 8'd1;
                        if (addr_left == 8'h00)
                            phase = P_PORT_HI;
                    end
                    P_PORT_HI:
                    begin
                        t.role = ROLE_PORT;
                        hold_byte = b;
                        phase = P_PORT_LO;
                    end
                    P_PORT_LO:
                    begin
                        t.role = ROLE_PORT;
                        if (hold_byte == 8'h00 && b == 8'h00)
                        begin
                            held_status = ST_BADADDR;
                            t.status = ST_BADADDR;
                        end
                        else
                            phase = P_LEN_HI;
                    end
                    P_LEN_HI:
                    begin
                        t.role = ROLE_LENGTH;
                        hold_byte = b;
                        phase = P_LEN_LO;
                    end
                    P_LEN_LO:
                    begin
                        t.role = ROLE_LENGTH;
                        payload_left = {hold_byte, b};
                        if (payload_left == 16'h0000)
                        begin
                            t.frame_last = 1'b1;
                            t.empty_frame = 1'b1;
                            phase = P_START;
                        end
                        else
                            phase = P_PAYLOAD;
                    end
                    default:
                    begin
                        t.role = ROLE_PAYLOAD;
                        payload_left = payload_left - 16'd1;
                        if (payload_left == 16'h0000)
                        begin
                            t.frame_last = 1'b1;
                            phase = P_START;
                        end
                    end
                endcase
            end
            tags_due.push_back(t);
        endfunction

        task report(string what);
            $display("[%0t] deframer tag mismatch: %s", $time, what);
            tag_mismatches++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (tags_due.size() == 0)
            begin
                report($sformatf("result beat with nothing due, byte %02h", got.out_byte));
                return;
            end
            want = tags_due.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            if (got.role !== want.role)
                report($sformatf("byte_role %0d, want %0d", got.role, want.role));
            if (got.frame_last !== want.frame_last)
                report($sformatf("frame_last %b, want %b", got.frame_last, want.frame_last));
            if (got.empty_frame !== want.empty_frame)
                report($sformatf("empty_frame %b, want %b", got.empty_frame,
                                 want.empty_frame));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
        endtask
    endclass

    logic clk;
    logic rst_n;

    utdf_in_if  data_if ();
    utdf_out_if res_if ();
    utdf_cfg_if cfg_if ();

    udp_over_tcp_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    deframe_scoreboard sb = new();

    logic [7:0]  frame_q[$];
    bit          mode_now;
    int unsigned src_idle_pct;
    int unsigned stall_pct;
    int unsigned beats_sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random back-pressure, check every accepted beat
    initial
    begin
        result_t got;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
            begin
                got.out_byte = res_if.out_byte;
                got.role = role_t'(res_if.byte_role);
                got.frame_last = res_if.frame_last;
                got.empty_frame = res_if.empty_frame;
                got.status = status_t'(res_if.status);
                sb.check_result(got);
            end
            @(negedge clk);
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(logic [7:0] b, logic eos);
        while ($urandom_range(99) < src_idle_pct)
        begin
            data_if.valid <= 1'b0;
            @(negedge clk);
        end
        data_if.valid <= 1'b1;
        data_if.in_byte <= b;
        data_if.end_of_stream <= eos;
        do
        begin
            @(posedge clk);
        end
        while (data_if.ready !== 1'b1);
        sb.note_beat(b, eos);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_range(int unsigned from, int unsigned upto);
        for (int unsigned i = from; i < upto; i++)
            send_beat(frame_q[i], 1'b0);
    endtask

    task automatic drain();
        data_if.valid <= 1'b0;
        while (sb.tags_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_mode(bit m);
        cfg_if.valid <= 1'b1;
        cfg_if.connect_mode <= m;
        do
        begin
            @(posedge clk);
        end
        while (cfg_if.ready !== 1'b1);
        sb.set_mode(m);
        mode_now = m;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void build_frame(bit hdr, logic [7:0] kind, logic [7:0] dom_len,
                                        logic [15:0] port, logic [15:0] len_field,
                                        int unsigned n_payload);
        int unsigned n_addr;
        frame_q.delete();
        if (hdr)
        begin
            frame_q.push_back(kind);
            if (kind == TYPE_IPV4)
                n_addr = 32'(IPV4_ADDR_LEN);
            else if (kind == TYPE_IPV6)
                n_addr = 32'(IPV6_ADDR_LEN);
            else
            begin
                frame_q.push_back(dom_len);
                n_addr = 32'(dom_len);
            end
            repeat (n_addr) frame_q.push_back(8'($urandom));
            frame_q.push_back(port[15:8]);
            frame_q.push_back(port[7:0]);
        end
        frame_q.push_back(len_field[15:8]);
        frame_q.push_back(len_field[7:0]);
        repeat (n_payload) frame_q.push_back(8'($urandom));
    endfunction

    function automatic void build_random_frame(bit hdr);
        logic [7:0]  kind;
        logic [7:0]  dom_len;
        logic [15:0] port;
        int unsigned len;
        case ($urandom_range(2))
            0: kind = TYPE_IPV4;
            1: kind = TYPE_IPV6;
            default: kind = TYPE_DOMAIN;
        endcase
        dom_len = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(1, 12));
        case ($urandom_range(7))
            0: port = 16'h0001;
            1: port = 16'h0100;
            2: port = 16'hFFFF;
            default: port = 16'($urandom_range(1, 16'hFFFF));
        endcase
        if ($urandom_range(5) == 0)
            len = 0;
        else if ($urandom_range(39) == 0)
            len = $urandom_range(100, 400);
        else
            len = $urandom_range(1, 24);
        build_frame(hdr, kind, dom_len, port, 16'(len), len);
    endfunction

    task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, int unsigned n_beats,
                             bit next_mode);
        int unsigned stop_at;
        int unsigned cut;
        src_idle_pct = src_pct;
        stall_pct = snk_pct;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at)
        begin
            build_random_frame(!mode_now);
            send_range(0, frame_q.size());
        end
        // mode write lands mid-frame; the frame keeps the format it started in
        build_random_frame(!mode_now);
        cut = $urandom_range(1, frame_q.size() - 1);
        send_range(0, cut);
        drain();
        write_mode(next_mode);
        send_range(cut, frame_q.size());
    endtask

    // Errors and clean end are sticky until reset, so one of them closes the run.
    task automatic end_stream();
        int unsigned ending;
        int unsigned cut;
        src_idle_pct = 20;
        stall_pct = 30;
        ending = $urandom_range(6);
        drain();
        case (ending)
            0:
            begin
                write_mode(1'b1);
                build_random_frame(1'b0);
                send_range(0, frame_q.size());
                send_beat(8'($urandom), 1'b1);
            end
            1:
            begin
                build_frame(!mode_now, TYPE_IPV4, 8'd1, 16'hFFFF, 16'hFFFF,
                            $urandom_range(0, 5));
                cut = $urandom_range(1, frame_q.size());
                send_range(0, cut);
                send_beat(8'($urandom), 1'b1);
            end
            2:
            begin
                write_mode(1'b0);
                build_random_frame(1'b1);
                send_range(0, frame_q.size());
                send_beat(8'($urandom), 1'b1);
            end
            3, 4:
            begin
                write_mode(1'b0);
                send_beat(8'($urandom_range(3, 255)), 1'b0);
                send_beat(8'($urandom), ending == 4);
            end
            5:
            begin
                write_mode(1'b0);
                send_beat(TYPE_DOMAIN, 1'b0);
                send_beat(8'h00, 1'b0);
            end
            default:
            begin
                // zero port; stop right after the second port byte
                write_mode(1'b0);
                build_frame(1'b1, TYPE_IPV4, 8'd1, 16'h0000, 16'd0, 0);
                send_range(0, frame_q.size() - 2);
            end
        endcase
        // held status on everything after
        repeat (6) send_beat(8'($urandom), 1'($urandom_range(1)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        data_if.valid = 1'b0;
        data_if.in_byte = 8'h00;
        data_if.end_of_stream = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.connect_mode = 1'b0;
        mode_now = 1'b0;
        src_idle_pct = 0;
        stall_pct = 0;
        beats_sent = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // header frames: empty IPv4 frame, one-byte domain name with port 0xffff
        build_frame(1'b1, TYPE_IPV4, 8'd0, 16'h0100, 16'd0, 0);
        send_range(0, frame_q.size());
        build_frame(1'b1, TYPE_DOMAIN, 8'd1, 16'hFFFF, 16'd1, 1);
        send_range(0, frame_q.size());
        drain();
        write_mode(1'b1);
        build_frame(1'b0, TYPE_IPV4, 8'd0, 16'd0, 16'd0, 0);
        send_range(0, frame_q.size());
        build_frame(1'b0, TYPE_IPV4, 8'd0, 16'd0, 16'd1, 1);
        send_range(0, frame_q.size());
        drain();
        write_mode(1'($urandom_range(1)));

        run_phase(8, 65, 620, !mode_now);
        run_phase(65, 8, 620, 1'($urandom_range(1)));
        run_phase(0, 0, 620, 1'($urandom_range(1)));
        end_stream();

        drain();
        repeat (4) @(posedge clk);
        if (sb.tag_mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
